// ----- rtl/transposition_table_engine_core_macros.svh -----
// Assertion macros used by the table engine back end (tte_back).
`ifndef TRANSPOSITION_TABLE_ENGINE_CORE_MACROS_SVH
`define TRANSPOSITION_TABLE_ENGINE_CORE_MACROS_SVH

// Check cons in the same cycle as ante.
`define TTE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define TTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tte_pkg.sv -----
package tte_pkg;

  localparam int DEF_BUCKET_COUNT = 1021;
  localparam int DEF_SPARE_COUNT  = 1024;

  localparam int KEY_W       = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_GET   = 2'd1;
  localparam logic [1:0] CMD_SWEEP = 2'd2;

  localparam logic [1:0] KIND_VACANT = 2'd0;
  localparam logic [1:0] KIND_EXACT  = 2'd1;
  localparam logic [1:0] KIND_ALPHA  = 2'd2;
  localparam logic [1:0] KIND_BETA   = 2'd3;

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_REPLACED  = 3'd1;
  localparam logic [2:0] ST_APPENDED  = 3'd2;
  localparam logic [2:0] ST_DISCARDED = 3'd3;
  localparam logic [2:0] ST_POOL_FULL = 3'd4;
  localparam logic [2:0] ST_SWEEP_ERR = 3'd5;

  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        position_key;
    logic [31:0]        position_lock;
    logic               side_to_move;
    logic signed [31:0] entry_value;
    logic [1:0]         entry_kind;
    logic [15:0]        search_depth;
  } tte_in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] found_value;
    logic [1:0]         found_kind;
    logic [15:0]        found_depth;
    logic [2:0]         status;
  } tte_out_t;

  typedef struct packed {
    logic [31:0]        key;
    logic [31:0]        lock;
    logic               side;
    logic signed [31:0] value;
    logic [1:0]         kind;
    logic [15:0]        depth;
    logic               used;
  } slot_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXAM,
    BK_APPEND,
    BK_SW_READ,
    BK_SW_EXAM,
    BK_SW_END,
    BK_DONE
  } back_state_t;

endpackage

// ----- rtl/tte_front.sv -----
module tte_front import tte_pkg::*; #(
  parameter int BUCKET_COUNT = DEF_BUCKET_COUNT,
  localparam int BKT_W = $clog2(BUCKET_COUNT)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tte_in_t          in_data,
  output logic             push_valid,
  input  logic             push_full,
  output tte_in_t          push_item,
  output logic [BKT_W-1:0] push_bucket
);

  localparam int PROD_W = 2 * KEY_W + 1;
  localparam int SHIFT  = KEY_W + BKT_W;
  localparam logic [KEY_W:0] RECIP = (KEY_W+1)'(((PROD_W'(1) << SHIFT) +
                                      PROD_W'(BUCKET_COUNT - 1)) / PROD_W'(BUCKET_COUNT));

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              phase_r, phase_nxt;
  tte_in_t           item_r, item_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [BKT_W-1:0]  rem_r, rem_nxt;
  logic [KEY_W-1:0]  quot;
  logic [KEY_W-1:0]  rem_full;

  assign quot     = KEY_W'(prod_r >> SHIFT);
  assign rem_full = item_r.position_key - quot * KEY_W'(BUCKET_COUNT);

  assign in_stall    = busy_r;
  assign push_valid  = busy_r && done_r;
  assign push_item   = item_r;
  assign push_bucket = rem_r;

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = done_r;
    phase_nxt = phase_r;
    item_nxt  = item_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    if (!busy_r) begin
      if (in_valid) begin
        busy_nxt  = 1'b1;
        done_nxt  = 1'b0;
        phase_nxt = 1'b0;
        item_nxt  = in_data;
      end
    end else if (!done_r) begin
      if (!phase_r) begin
        prod_nxt  = PROD_W'(item_r.position_key) * PROD_W'(RECIP);
        phase_nxt = 1'b1;
      end else begin
        rem_nxt  = rem_full[BKT_W-1:0];
        done_nxt = 1'b1;
      end
    end else if (!push_full) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      phase_r <= phase_nxt;
    end
    item_r <= item_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
  end

endmodule

// ----- rtl/tte_queue.sv -----
module tte_queue import tte_pkg::*; #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          valid
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DW-1:0]    buf_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = cnt_r == CNT_W'(QUEUE_DEPTH);
  assign valid    = cnt_r != '0;
  assign pop_data = buf_r[rd_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      buf_r[wr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/tte_back.sv -----
module tte_back import tte_pkg::*; #(
  parameter int BUCKET_COUNT = DEF_BUCKET_COUNT,
  parameter int SPARE_COUNT  = DEF_SPARE_COUNT,
  localparam int BKT_W = $clog2(BUCKET_COUNT)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  tte_in_t          q_item,
  input  logic [BKT_W-1:0] q_bucket,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output tte_out_t         out_data
);

  `include "transposition_table_engine_core_macros.svh"

  localparam int SPI_W    = (SPARE_COUNT > 1) ? $clog2(SPARE_COUNT) : 1;
  localparam int LNK_W    = $clog2(SPARE_COUNT + 1);
  localparam int SP_DEPTH = 2 ** (SPI_W + 1);

  slot_t            head_slot_mem [BUCKET_COUNT];
  logic [LNK_W-1:0] head_link_mem [BUCKET_COUNT];
  slot_t            sp_slot_mem [SP_DEPTH];
  logic [LNK_W-1:0] sp_link_mem [SP_DEPTH];

  logic             head_we, head_re;
  logic [BKT_W-1:0] head_waddr, head_raddr;
  slot_t            head_wslot, head_q_slot;
  logic [LNK_W-1:0] head_wlink, head_q_link;
  logic             sp_we, sp_re;
  logic [SPI_W:0]   sp_waddr, sp_raddr;
  slot_t            sp_wslot, sp_q_slot;
  logic [LNK_W-1:0] sp_wlink, sp_q_link;

  back_state_t      state_r, state_nxt;
  tte_in_t          item_r, item_nxt;
  logic [BKT_W-1:0] bkt_r, bkt_nxt;
  logic [BKT_W-1:0] cnt_r, cnt_nxt;
  logic             on_head_r, on_head_nxt;
  logic [SPI_W-1:0] idx_r, idx_nxt;
  logic [LNK_W-1:0] fill_r, fill_nxt;
  logic             bank_r, bank_nxt;
  logic [LNK_W-1:0] nf_r, nf_nxt;
  logic [LNK_W-1:0] nf0_r, nf0_nxt;
  slot_t            first_r, first_nxt;
  logic             have_first_r, have_first_nxt;
  slot_t            pend_r, pend_nxt;
  logic             have_pend_r, have_pend_nxt;
  logic             err_r, err_nxt;
  tte_out_t         res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  tte_out_t         out_data_r;
  logic             out_load;

  slot_t            cur;
  logic [LNK_W-1:0] cur_link;
  slot_t            new_slot;
  logic             same_pos, deeper, over, disc;
  logic             pool_full;
  logic [LNK_W-1:0] link_dec;

  assign cur      = on_head_r ? head_q_slot : sp_q_slot;
  assign cur_link = on_head_r ? head_q_link : sp_q_link;
  assign link_dec = cur_link - 1'b1;
  assign same_pos = cur.key == item_r.position_key && cur.lock == item_r.position_lock
                    && cur.side == item_r.side_to_move;
  assign deeper   = item_r.search_depth > cur.depth;
  assign over     = (cur.kind == KIND_VACANT) || (same_pos &&
                    ((item_r.entry_kind == KIND_EXACT &&
                      (cur.kind == KIND_ALPHA || cur.kind == KIND_BETA)) ||
                     (item_r.entry_kind == cur.kind && deeper)));
  assign disc     = same_pos && item_r.entry_kind == cur.kind && !deeper;
  assign pool_full = fill_r == LNK_W'(SPARE_COUNT);

  always_comb begin
    new_slot       = '0;
    new_slot.key   = item_r.position_key;
    new_slot.lock  = item_r.position_lock;
    new_slot.side  = item_r.side_to_move;
    new_slot.value = item_r.entry_value;
    new_slot.kind  = item_r.entry_kind;
    new_slot.depth = item_r.search_depth;
    new_slot.used  = 1'b0;
  end

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    bkt_nxt        = bkt_r;
    cnt_nxt        = cnt_r;
    on_head_nxt    = on_head_r;
    idx_nxt        = idx_r;
    fill_nxt       = fill_r;
    bank_nxt       = bank_r;
    nf_nxt         = nf_r;
    nf0_nxt        = nf0_r;
    first_nxt      = first_r;
    have_first_nxt = have_first_r;
    pend_nxt       = pend_r;
    have_pend_nxt  = have_pend_r;
    err_nxt        = err_r;
    res_nxt        = res_r;
    head_we        = 1'b0;
    head_waddr     = bkt_r;
    head_wslot     = '0;
    head_wlink     = '0;
    head_re        = 1'b0;
    head_raddr     = bkt_r;
    sp_we          = 1'b0;
    sp_waddr       = {bank_r, idx_r};
    sp_wslot       = '0;
    sp_wlink       = '0;
    sp_re          = 1'b0;
    sp_raddr       = {bank_r, link_dec[SPI_W-1:0]};
    q_pop          = 1'b0;
    out_load       = 1'b0;

    unique case (state_r)
      BK_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = cnt_r;
        if (cnt_r == BKT_W'(BUCKET_COUNT - 1)) begin
          cnt_nxt   = '0;
          state_nxt = BK_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      BK_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          item_nxt    = q_item;
          bkt_nxt     = q_bucket;
          res_nxt     = '0;
          on_head_nxt = 1'b1;
          unique case (q_item.command)
            CMD_PUT: begin
              if (q_item.entry_kind == KIND_VACANT) begin
                state_nxt = BK_DONE;
              end else begin
                head_re    = 1'b1;
                head_raddr = q_bucket;
                state_nxt  = BK_EXAM;
              end
            end
            CMD_GET: begin
              head_re    = 1'b1;
              head_raddr = q_bucket;
              state_nxt  = BK_EXAM;
            end
            CMD_SWEEP: begin
              cnt_nxt        = '0;
              nf_nxt         = '0;
              nf0_nxt        = '0;
              have_first_nxt = 1'b0;
              have_pend_nxt  = 1'b0;
              err_nxt        = 1'b0;
              state_nxt      = BK_SW_READ;
            end
            default: begin
              state_nxt = BK_DONE;
            end
          endcase
        end
      end

      BK_EXAM: begin
        if (item_r.command == CMD_PUT) begin
          if (over) begin
            head_we        = on_head_r;
            sp_we          = !on_head_r;
            head_wslot     = new_slot;
            sp_wslot       = new_slot;
            head_wlink     = cur_link;
            sp_wlink       = cur_link;
            res_nxt.status = ST_REPLACED;
            state_nxt      = BK_DONE;
          end else if (disc) begin
            res_nxt.status = ST_DISCARDED;
            state_nxt      = BK_DONE;
          end else if (cur_link == '0) begin
            if (pool_full) begin
              res_nxt.status = ST_POOL_FULL;
              state_nxt      = BK_DONE;
            end else begin
              sp_we     = 1'b1;
              sp_waddr  = {bank_r, fill_r[SPI_W-1:0]};
              sp_wslot  = new_slot;
              sp_wlink  = '0;
              state_nxt = BK_APPEND;
            end
          end else begin
            sp_re       = 1'b1;
            idx_nxt     = link_dec[SPI_W-1:0];
            on_head_nxt = 1'b0;
          end
        end else begin
          if (on_head_r && cur.kind == KIND_VACANT) begin
            state_nxt = BK_DONE;
          end else if (same_pos) begin
            head_we             = on_head_r;
            sp_we               = !on_head_r;
            head_wslot          = cur;
            head_wslot.used     = 1'b1;
            sp_wslot            = head_wslot;
            head_wlink          = cur_link;
            sp_wlink            = cur_link;
            res_nxt.hit         = 1'b1;
            res_nxt.found_value = cur.value;
            res_nxt.found_kind  = cur.kind;
            res_nxt.found_depth = cur.depth;
            state_nxt           = BK_DONE;
          end else if (cur_link == '0) begin
            state_nxt = BK_DONE;
          end else begin
            sp_re       = 1'b1;
            idx_nxt     = link_dec[SPI_W-1:0];
            on_head_nxt = 1'b0;
          end
        end
      end

      BK_APPEND: begin
        head_we        = on_head_r;
        sp_we          = !on_head_r;
        head_wslot     = cur;
        sp_wslot       = cur;
        head_wlink     = fill_r + 1'b1;
        sp_wlink       = fill_r + 1'b1;
        fill_nxt       = fill_r + 1'b1;
        res_nxt.status = ST_APPENDED;
        state_nxt      = BK_DONE;
      end

      BK_SW_READ: begin
        head_re     = 1'b1;
        head_raddr  = cnt_r;
        on_head_nxt = 1'b1;
        state_nxt   = BK_SW_EXAM;
      end

      BK_SW_EXAM: begin
        if (on_head_r && cur.kind == KIND_VACANT) begin
          state_nxt = BK_SW_END;
        end else begin
          if (cur.used) begin
            if (!have_first_r) begin
              first_nxt      = cur;
              first_nxt.used = 1'b0;
              have_first_nxt = 1'b1;
            end else begin
              if (have_pend_r) begin
                if (nf_r == LNK_W'(SPARE_COUNT)) begin
                  err_nxt = 1'b1;
                end else begin
                  sp_we    = 1'b1;
                  sp_waddr = {!bank_r, nf_r[SPI_W-1:0]};
                  sp_wslot = pend_r;
                  sp_wlink = nf_r + LNK_W'(2);
                  nf_nxt   = nf_r + 1'b1;
                end
              end
              pend_nxt      = cur;
              pend_nxt.used = 1'b0;
              have_pend_nxt = 1'b1;
            end
          end
          if (cur_link == '0) begin
            state_nxt = BK_SW_END;
          end else begin
            sp_re       = 1'b1;
            on_head_nxt = 1'b0;
          end
        end
      end

      BK_SW_END: begin
        head_we    = 1'b1;
        head_waddr = cnt_r;
        if (have_first_r) begin
          head_wslot = first_r;
          head_wlink = have_pend_r ? nf0_r + 1'b1 : '0;
        end
        if (have_pend_r) begin
          if (nf_r == LNK_W'(SPARE_COUNT)) begin
            err_nxt = 1'b1;
          end else begin
            sp_we    = 1'b1;
            sp_waddr = {!bank_r, nf_r[SPI_W-1:0]};
            sp_wslot = pend_r;
            sp_wlink = '0;
            nf_nxt   = nf_r + 1'b1;
          end
        end
        have_first_nxt = 1'b0;
        have_pend_nxt  = 1'b0;
        nf0_nxt        = nf_nxt;
        if (cnt_r == BKT_W'(BUCKET_COUNT - 1)) begin
          bank_nxt       = !bank_r;
          fill_nxt       = nf_nxt;
          res_nxt.status = err_nxt ? ST_SWEEP_ERR : ST_DONE;
          cnt_nxt        = '0;
          state_nxt      = BK_DONE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = BK_SW_READ;
        end
      end

      BK_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end

      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_CLEAR;
      cnt_r        <= '0;
      fill_r       <= '0;
      bank_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      have_first_r <= 1'b0;
      have_pend_r  <= 1'b0;
      err_r        <= 1'b0;
      on_head_r    <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      fill_r       <= fill_nxt;
      bank_r       <= bank_nxt;
      out_valid_r  <= out_valid_nxt;
      have_first_r <= have_first_nxt;
      have_pend_r  <= have_pend_nxt;
      err_r        <= err_nxt;
      on_head_r    <= on_head_nxt;
    end
    item_r  <= item_nxt;
    bkt_r   <= bkt_nxt;
    idx_r   <= idx_nxt;
    nf_r    <= nf_nxt;
    nf0_r   <= nf0_nxt;
    first_r <= first_nxt;
    pend_r  <= pend_nxt;
    res_r   <= res_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_slot_mem[head_waddr] <= head_wslot;
      head_link_mem[head_waddr] <= head_wlink;
    end
    if (head_re) begin
      head_q_slot <= head_slot_mem[head_raddr];
      head_q_link <= head_link_mem[head_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (sp_we) begin
      sp_slot_mem[sp_waddr] <= sp_wslot;
      sp_link_mem[sp_waddr] <= sp_wlink;
    end
    if (sp_re) begin
      sp_q_slot <= sp_slot_mem[sp_raddr];
      sp_q_link <= sp_link_mem[sp_raddr];
    end
  end

  `TTE_ASSERT_IMPLY(a_fill_bound, clk, rst_n, 1'b1, fill_r <= LNK_W'(SPARE_COUNT), "spare fill beyond pool")
  `TTE_ASSERT_IMPLY(a_no_pop_clear, clk, rst_n, state_r == BK_CLEAR, !q_pop, "transaction taken during clear")
  `TTE_ASSERT_NEXT(a_fill_step, clk, rst_n, state_r == BK_APPEND, fill_r == LNK_W'($past(fill_r) + 1'b1), "append did not advance fill")
  `TTE_ASSERT_NEXT(a_bank_flip, clk, rst_n, state_r == BK_SW_END && cnt_r == BKT_W'(BUCKET_COUNT - 1), bank_r != $past(bank_r), "sweep did not swap pool bank")

endmodule

// ----- rtl/transposition_table_engine_core.sv -----
// Chained hash table of search positions.
// Input channel (in_valid/in_stall/in_data): one transaction per command:
// put, get or sweep. Result channel (out_valid/out_stall/out_data): exactly
// one result per command, in command order.
// The front maps the key to a bucket (key modulo BUCKET_COUNT by reciprocal
// multiplication, a registered product and then a registered remainder) and
// hands it through a two-entry queue to the back, which walks the chain in
// head and spare memories. The front takes no new transaction until it has
// pushed the last one into the queue; the back takes the next one from the
// queue only after loading its result; the slower one sets the throughput.
// Sweep: every bucket and its chain is read once. Survivors are packed into
// the second bank of the spare memory, then the banks swap.
// Reset: the back clears the head memory, one bucket a cycle, and takes no
// transaction meanwhile.
// A stalled result is held in the output register; the back stops behind
// it, the queue fills and the front cannot push, so in_stall stays high.
module transposition_table_engine_core import tte_pkg::*; #(
  parameter int BUCKET_COUNT = DEF_BUCKET_COUNT,
  parameter int SPARE_COUNT  = DEF_SPARE_COUNT
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tte_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output tte_out_t out_data
);

  localparam int BKT_W = $clog2(BUCKET_COUNT);
  localparam int DW    = $bits(tte_in_t) + BKT_W;

  logic             push_valid, push_full;
  tte_in_t          push_item;
  logic [BKT_W-1:0] push_bucket;
  logic             q_valid, q_pop;
  logic [DW-1:0]    q_data;
  tte_in_t          q_item;
  logic [BKT_W-1:0] q_bucket;

  tte_front #(.BUCKET_COUNT(BUCKET_COUNT)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .push_valid  (push_valid),
    .push_full   (push_full),
    .push_item   (push_item),
    .push_bucket (push_bucket)
  );

  tte_queue #(.DW(DW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data ({push_item, push_bucket}),
    .full      (push_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .valid     (q_valid)
  );

  assign q_item   = q_data[DW-1:BKT_W];
  assign q_bucket = q_data[BKT_W-1:0];

  tte_back #(
    .BUCKET_COUNT (BUCKET_COUNT),
    .SPARE_COUNT  (SPARE_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_bucket  (q_bucket),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- sim/testbench.sv -----
module testbench;
  import tte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUCKETS = DEF_BUCKET_COUNT;
  localparam int SPARES = DEF_SPARE_COUNT;
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int IDLE_LIMIT = 60000;
  localparam int POSITIONS = 48;

  typedef struct {
    logic [31:0] key;
    logic [31:0] lock;
    logic side;
    logic signed [31:0] value;
    logic [1:0] kind;
    logic [15:0] depth;
    logic used;
    int link;
  } tt_entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tte_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tte_out_t out_data;

  tt_entry_t tab[0:BUCKETS+SPARES-1];
  tt_entry_t fresh[0:SPARES-1];
  int spare_fill = 0;

  tte_in_t stim_q[$];
  tte_out_t response_q[$];
  int errors = 0;
  int sent_cnt = 0;
  int seen_cnt = 0;
  int gap = 0;
  int hold_cnt = 0;
  int idle_cycles = 0;

  logic [31:0] pos_key[POSITIONS];
  logic [31:0] pos_lock[POSITIONS];
  logic pos_side[POSITIONS];

  transposition_table_engine_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit same_position(int idx, tte_in_t t);
    return tab[idx].key == t.position_key && tab[idx].lock == t.position_lock &&
           tab[idx].side == t.side_to_move;
  endfunction

  function automatic void store_entry(int idx, tte_in_t t);
    tab[idx].key = t.position_key;
    tab[idx].lock = t.position_lock;
    tab[idx].side = t.side_to_move;
    tab[idx].value = t.entry_value;
    tab[idx].kind = t.entry_kind;
    tab[idx].depth = t.search_depth;
    tab[idx].used = 1'b0;
  endfunction

  function automatic logic [2:0] put_entry(tte_in_t t);
    int cur;
    int steps;
    int n;
    if (t.entry_kind == KIND_VACANT) return ST_DONE;
    cur = int'(t.position_key % 32'd1021);
    steps = 0;
    while (1) begin
      if (tab[cur].kind == KIND_VACANT) begin
        store_entry(cur, t);
        return ST_REPLACED;
      end
      if (same_position(cur, t)) begin
        if (t.entry_kind == KIND_EXACT &&
            (tab[cur].kind == KIND_ALPHA || tab[cur].kind == KIND_BETA)) begin
          store_entry(cur, t);
          return ST_REPLACED;
        end
        if (t.entry_kind == tab[cur].kind) begin
          if (t.search_depth > tab[cur].depth) begin
            store_entry(cur, t);
            return ST_REPLACED;
          end
          return ST_DISCARDED;
        end
      end
      steps++;
      if (tab[cur].link == 0 || steps > SPARES) break;
      cur = BUCKETS + tab[cur].link - 1;
    end
    if (spare_fill >= SPARES) return ST_POOL_FULL;
    n = BUCKETS + spare_fill;
    store_entry(n, t);
    tab[n].link = 0;
    spare_fill++;
    tab[cur].link = spare_fill;
    return ST_APPENDED;
  endfunction

  function automatic tte_out_t get_entry(tte_in_t t);
    tte_out_t r;
    int cur;
    r = '0;
    cur = int'(t.position_key % 32'd1021);
    if (tab[cur].kind == KIND_VACANT) return r;
    while (1) begin
      if (same_position(cur, t)) begin
        tab[cur].used = 1'b1;
        r.hit = 1'b1;
        r.found_value = tab[cur].value;
        r.found_kind = tab[cur].kind;
        r.found_depth = tab[cur].depth;
        return r;
      end
      if (tab[cur].link == 0) return r;
      cur = BUCKETS + tab[cur].link - 1;
    end
  endfunction

  function automatic void sweep_table();
    tt_entry_t keep[$];
    tt_entry_t e;
    int cur;
    int nf;
    int tail;
    nf = 0;
    for (int b = 0; b < BUCKETS; b++) begin
      if (tab[b].kind == KIND_VACANT) begin
        tab[b].link = 0;
        tab[b].used = 1'b0;
        continue;
      end
      keep.delete();
      cur = b;
      while (cur >= 0) begin
        if (tab[cur].used) begin
          e = tab[cur];
          e.used = 1'b0;
          e.link = 0;
          keep.push_back(e);
        end
        cur = (tab[cur].link == 0) ? -1 : BUCKETS + tab[cur].link - 1;
      end
      if (keep.size() == 0) begin
        tab[b] = '{default: '0};
        continue;
      end
      tab[b] = keep[0];
      tail = -1;
      for (int k = 1; k < keep.size(); k++) begin
        fresh[nf] = keep[k];
        nf++;
        if (tail < 0) tab[b].link = nf;
        else fresh[tail].link = nf;
        tail = nf - 1;
      end
    end
    for (int i = 0; i < SPARES; i++) begin
      tab[BUCKETS+i] = (i < nf) ? fresh[i] : '{default: '0};
    end
    spare_fill = nf;
  endfunction

  function automatic tte_out_t apply_command(tte_in_t t);
    tte_out_t r;
    r = '0;
    case (t.command)
      CMD_PUT: r.status = put_entry(t);
      CMD_GET: r = get_entry(t);
      CMD_SWEEP: sweep_table();
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic int draw_wait(int count);
    return ((count / 250) % 4 == 3) ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic add_item(logic [1:0] cmd, logic [31:0] key, logic [31:0] lock,
                          logic side, logic [31:0] val, logic [1:0] kind,
                          logic [15:0] depth);
    tte_in_t t;
    t.command = cmd;
    t.position_key = key;
    t.position_lock = lock;
    t.side_to_move = side;
    t.entry_value = val;
    t.entry_kind = kind;
    t.search_depth = depth;
    stim_q.push_back(t);
  endtask

  task automatic add_random_item();
    int r;
    int p;
    logic [31:0] lock;
    logic side;
    r = $urandom_range(0, 99);
    p = $urandom_range(0, POSITIONS - 1);
    lock = pos_lock[p];
    side = pos_side[p];
    if (r < 45) begin
      add_item(CMD_PUT, pos_key[p], lock, side, $urandom, 2'($urandom_range(0, 3)),
               ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7)));
    end else if (r < 85) begin
      if ($urandom_range(0, 7) == 0) side = ~side;
      if ($urandom_range(0, 7) == 0) lock = $urandom;
      add_item(CMD_GET, pos_key[p], lock, side, $urandom, 2'($urandom_range(0, 3)),
               16'($urandom));
    end else if (r < 87) begin
      add_item(CMD_SWEEP, $urandom, $urandom, 1'($urandom_range(0, 1)), $urandom,
               2'($urandom_range(0, 3)), 16'($urandom));
    end else if (r < 92) begin
      add_item(CMD_NOP, $urandom, $urandom, 1'($urandom_range(0, 1)), $urandom,
               2'($urandom_range(0, 3)), 16'($urandom));
    end else begin
      add_item(logic'($urandom_range(0, 1)) ? CMD_GET : CMD_PUT, $urandom, $urandom,
               1'($urandom_range(0, 1)), $urandom, 2'($urandom_range(0, 3)),
               16'($urandom));
    end
  endtask

  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap <= 0;
    end else if (in_valid && !in_stall) begin
      response_q.push_back(apply_command(in_data));
      sent_cnt <= sent_cnt + 1;
      w = draw_wait(sent_cnt);
      if (w == 0 && stim_q.size() > 0) begin
        in_data <= stim_q.pop_front();
      end else begin
        in_valid <= 1'b0;
        gap <= w;
      end
    end else if (!in_valid) begin
      if (gap > 0) begin
        gap <= gap - 1;
      end else if (stim_q.size() > 0) begin
        in_data <= stim_q.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    tte_out_t exp_r;
    int w;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen_cnt <= seen_cnt + 1;
        if (response_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result transaction: %p", out_data);
        end else begin
          exp_r = response_q.pop_front();
          if (out_data.hit !== exp_r.hit || out_data.found_value !== exp_r.found_value ||
              out_data.found_kind !== exp_r.found_kind ||
              out_data.found_depth !== exp_r.found_depth ||
              out_data.status !== exp_r.status) begin
            errors <= errors + 1;
            if (errors < 10) begin
              $display("mismatch at result %0d: expected hit=%0d value=%0d kind=%0d depth=%0d status=%0d, got hit=%0d value=%0d kind=%0d depth=%0d status=%0d",
                       seen_cnt, exp_r.hit, exp_r.found_value, exp_r.found_kind,
                       exp_r.found_depth, exp_r.status, out_data.hit,
                       out_data.found_value, out_data.found_kind,
                       out_data.found_depth, out_data.status);
            end
          end
        end
      end
      if (hold_cnt > 1) begin
        hold_cnt <= hold_cnt - 1;
      end else if (hold_cnt == 1) begin
        hold_cnt <= 0;
        out_stall <= 1'b0;
      end else if (out_valid && !out_stall) begin
        w = (seen_cnt == 400) ? 500 : draw_wait(seen_cnt + 125);
        if (w > 0) begin
          out_stall <= 1'b1;
          hold_cnt <= w;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < BUCKETS + SPARES; i++) tab[i] = '{default: '0};
    for (int i = 0; i < SPARES; i++) fresh[i] = '{default: '0};
    for (int i = 0; i < POSITIONS; i++) begin
      pos_key[i] = 32'($urandom_range(0, 5)) + 32'd1021 * 32'($urandom_range(0, 4000000));
      pos_lock[i] = $urandom;
      pos_side[i] = 1'($urandom_range(0, 1));
    end
    pos_key[0] = 32'd0;
    pos_key[1] = 32'd1021;
    pos_key[2] = 32'hFFFFFFFF;

    add_item(CMD_PUT, 32'd0, 32'h0, 1'b0, 32'h80000000, KIND_EXACT, 16'd0);
    add_item(CMD_GET, 32'd0, 32'h0, 1'b0, 32'h0, KIND_VACANT, 16'd0);
    add_item(CMD_PUT, 32'd0, 32'h0, 1'b0, 32'h1, KIND_EXACT, 16'd0);
    add_item(CMD_PUT, 32'd0, 32'h0, 1'b0, 32'h2, KIND_EXACT, 16'hFFFF);
    add_item(CMD_PUT, 32'd0, 32'h0, 1'b0, 32'h3, KIND_ALPHA, 16'd5);
    add_item(CMD_PUT, 32'd0, 32'h0, 1'b0, 32'h4, KIND_ALPHA, 16'd9);
    add_item(CMD_PUT, 32'd0, 32'h0, 1'b0, 32'h5, KIND_BETA, 16'd3);
    add_item(CMD_PUT, 32'd0, 32'h0, 1'b0, 32'h6, KIND_VACANT, 16'd7);
    add_item(CMD_GET, 32'd0, 32'h0, 1'b1, 32'h0, KIND_VACANT, 16'd0);
    add_item(CMD_GET, 32'd0, 32'hFFFFFFFF, 1'b0, 32'h0, KIND_VACANT, 16'd0);
    add_item(CMD_PUT, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h7FFFFFFF, KIND_BETA, 16'hFFFF);
    add_item(CMD_GET, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, KIND_BETA, 16'hFFFF);
    add_item(CMD_PUT, 32'd1021, 32'h5A5A5A5A, 1'b1, 32'hFFFFFFFF, KIND_ALPHA, 16'd1);
    add_item(CMD_GET, 32'd1021, 32'h5A5A5A5A, 1'b1, 32'h0, KIND_VACANT, 16'd0);
    add_item(CMD_PUT, 32'd1021, 32'h5A5A5A5A, 1'b1, 32'h8, KIND_EXACT, 16'd0);
    add_item(CMD_NOP, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, KIND_BETA, 16'hFFFF);
    add_item(CMD_SWEEP, 32'd0, 32'd0, 1'b0, 32'd0, KIND_VACANT, 16'd0);
    add_item(CMD_GET, 32'd0, 32'h0, 1'b0, 32'h0, KIND_VACANT, 16'd0);
    add_item(CMD_GET, 32'd1021, 32'h5A5A5A5A, 1'b1, 32'h0, KIND_VACANT, 16'd0);
    add_item(CMD_GET, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h0, KIND_VACANT, 16'd0);
    add_item(CMD_SWEEP, 32'd0, 32'd0, 1'b0, 32'd0, KIND_VACANT, 16'd0);
    add_item(CMD_SWEEP, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, KIND_BETA, 16'hFFFF);
    add_item(CMD_GET, 32'd0, 32'h0, 1'b0, 32'h0, KIND_VACANT, 16'd0);

    for (int i = 0; i < 430; i++) add_random_item();

    // chain long lists behind a few heads until the spare pool runs full,
    // marking some entries used
    for (int i = 0; i < 1100; i++) begin
      add_item(CMD_PUT, 32'(i % 32) + 32'd1021 * 32'($urandom_range(0, 4000000)),
               $urandom, 1'($urandom_range(0, 1)), $urandom, 2'($urandom_range(1, 3)),
               16'($urandom));
      if (i % 8 == 0) begin
        tte_in_t t;
        t = stim_q[stim_q.size()-1];
        t.command = CMD_GET;
        stim_q.push_back(t);
      end
    end
    add_item(CMD_SWEEP, 32'd0, 32'd0, 1'b0, 32'd0, KIND_VACANT, 16'd0);
    for (int i = 0; i < 60; i++) add_random_item();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk);
    while (stim_q.size() > 0 || in_valid || response_q.size() > 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && response_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
